[hdl/atan_pkg.sv]
package atan_pkg;

  localparam int unsigned CoordWidthDef     = 32;
  localparam int unsigned RatioFracBitsDef  = 30;
  localparam int unsigned AngleWidth        = 31;
  localparam int unsigned MaxTermsWidth     = 6;
  localparam int unsigned ThreshWidth       = 10;
  localparam int unsigned CfgDataWidth      = 10;
  localparam int unsigned CfgIdxWidth       = 1;
  localparam int unsigned TermLimit         = 50;
  localparam int unsigned DivisorWidth      = 7;

  localparam logic [CfgIdxWidth-1:0] CfgMaxTerms = 1'b0;
  localparam logic [CfgIdxWidth-1:0] CfgThresh   = 1'b1;

  localparam logic signed [AngleWidth-1:0] PiQ     = 31'sd843314857;
  localparam logic signed [AngleWidth-1:0] HalfPiQ = 31'sd421657428;

  typedef enum logic [2:0] {
    DpNop,
    DpLoad,
    DpDivStart,
    DpMulStart,
    DpTermAcc,
    DpFinish
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   odd;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic special;
    logic below;
  } dp_stat_t;

endpackage

[hdl/atan_ctrl.sv]
module atan_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  input  logic [atan_pkg::MaxTermsWidth-1:0] max_terms_i,
  input  atan_pkg::dp_stat_t                stat_i,
  output atan_pkg::dp_cmd_t                 cmd_o
);
  import atan_pkg::*;

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StRatio   = 3'd1;
  localparam logic [2:0] StDivTerm = 3'd2;
  localparam logic [2:0] StAcc     = 3'd3;
  localparam logic [2:0] StMul     = 3'd4;
  localparam logic [2:0] StCheck   = 3'd5;
  localparam logic [2:0] StFinish  = 3'd6;
  localparam logic [2:0] StOut     = 3'd7;

  logic [2:0] state_q, state_d;
  logic [MaxTermsWidth-1:0] idx_q, idx_d, nterms;
  logic out_valid_q, out_valid_d;

  always_comb begin
    nterms = max_terms_i;
    if (max_terms_i == '0) nterms = MaxTermsWidth'(1);
    if (max_terms_i > MaxTermsWidth'(TermLimit)) nterms = MaxTermsWidth'(TermLimit);
  end

  assign in_stall_o  = (state_q != StIdle) || out_valid_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.op = DpNop;
    cmd_o.odd = idx_q[0];
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && !in_stall_o) begin
          cmd_o.op = DpLoad;
          state_d = StRatio;
        end
      end
      StRatio: begin
        if (stat_i.special) begin
          state_d = StFinish;
        end else begin
          cmd_o.op = DpDivStart;
          idx_d = '0;
          state_d = StDivTerm;
        end
      end
      StDivTerm: begin
        if (!stat_i.busy) state_d = StAcc;
      end
      StAcc: begin
        cmd_o.op = DpTermAcc;
        state_d = StMul;
      end
      StMul: begin
        cmd_o.op = DpMulStart;
        state_d = StCheck;
      end
      StCheck: begin
        if (!stat_i.busy) begin
          if (idx_q + MaxTermsWidth'(1) >= nterms || stat_i.below) begin
            state_d = StFinish;
          end else begin
            idx_d = idx_q + MaxTermsWidth'(1);
            state_d = StAcc;
          end
        end
      end
      StFinish: begin
        cmd_o.op = DpFinish;
        state_d = StOut;
      end
      StOut: begin
        out_valid_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> state_q == StIdle)
    else $error("result shown while working");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle && in_valid_i && !in_stall_o) |=> state_q == StRatio)
    else $error("accepted item not started");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StCheck |-> idx_q < MaxTermsWidth'(TermLimit))
    else $error("term index overrun");

endmodule

[hdl/atan_dp.sv]
module atan_dp #(
  parameter int unsigned COORD_WIDTH     = atan_pkg::CoordWidthDef,
  parameter int unsigned RATIO_FRAC_BITS = atan_pkg::RatioFracBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [COORD_WIDTH-1:0]       y_i,
  input  logic signed [COORD_WIDTH-1:0]       x_i,
  input  logic [atan_pkg::ThreshWidth-1:0]    thresh_i,
  input  atan_pkg::dp_cmd_t                   cmd_i,
  output atan_pkg::dp_stat_t                  stat_o,
  output logic signed [atan_pkg::AngleWidth-1:0] angle_o
);
  import atan_pkg::*;

  localparam int unsigned QW   = RATIO_FRAC_BITS + 1;
  localparam int unsigned NW   = COORD_WIDTH + RATIO_FRAC_BITS;
  localparam int unsigned CntW = $clog2(NW + 1);
  localparam int unsigned SumW = QW + 1;

  // Shared restoring divider: numerator shifted in one bit per cycle.
  logic [NW-1:0] num_q;
  logic [COORD_WIDTH-1:0] den_q;
  logic [COORD_WIDTH:0] rem_q;
  logic [CntW-1:0] cnt_q;
  logic div_busy_q;
  logic [COORD_WIDTH:0] rem_sh;
  logic rem_ge;

  logic [COORD_WIDTH-1:0] ym_q, xm_q;
  logic yneg_q, xneg_q, inv_q, special_q;
  logic [QW-1:0] q_q, p_q, tmp_q;
  logic [DivisorWidth-1:0] dv_q;
  logic signed [SumW:0] sum_q;
  logic [1:0] mul_ph_q;
  logic mul_busy_q, div_mode_q;
  logic [2*QW-1:0] prod;
  logic [QW-1:0] prod_sh;
  logic signed [AngleWidth-1:0] angle_q;

  logic [COORD_WIDTH-1:0] ymag, xmag;
  assign ymag = y_i[COORD_WIDTH-1] ? COORD_WIDTH'(-y_i) : COORD_WIDTH'(y_i);
  assign xmag = x_i[COORD_WIDTH-1] ? COORD_WIDTH'(-x_i) : COORD_WIDTH'(x_i);

  assign rem_sh = {rem_q[COORD_WIDTH-1:0], num_q[NW-1]};
  assign rem_ge = rem_sh >= {1'b0, den_q};
  assign prod = (mul_ph_q == 2'd1 ? p_q : tmp_q) * q_q;
  assign prod_sh = QW'(prod >> RATIO_FRAC_BITS);

  logic [COORD_WIDTH-1:0] sm, bg;
  assign sm = inv_q ? xm_q : ym_q;
  assign bg = inv_q ? ym_q : xm_q;

  logic [QW-1:0] quot;
  assign quot = QW'(num_q);

  logic signed [SumW:0] sum_c;
  logic [SumW:0] mag;
  logic signed [AngleWidth-1:0] a, r;
  always_comb begin
    sum_c = sum_q < 0 ? '0 : sum_q;
    mag = unsigned'(sum_c);
    if (RATIO_FRAC_BITS >= 28) a = AngleWidth'(mag >> (RATIO_FRAC_BITS - 28));
    else a = AngleWidth'(mag << (28 - RATIO_FRAC_BITS));
    r = inv_q ? HalfPiQ - a : a;
    if (ym_q != '0 && (yneg_q != xneg_q)) r = -r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      mul_busy_q <= 1'b0;
      mul_ph_q <= '0;
      cnt_q <= '0;
    end else begin
      if (div_busy_q) begin
        rem_q <= rem_ge ? rem_sh - {1'b0, den_q} : rem_sh;
        num_q <= {num_q[NW-2:0], rem_ge};
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) div_busy_q <= 1'b0;
      end
      if (mul_busy_q) begin
        if (mul_ph_q == 2'd1) begin
          tmp_q <= prod_sh;
          mul_ph_q <= 2'd2;
        end else if (mul_ph_q == 2'd2) begin
          p_q <= prod_sh;
          num_q <= NW'(prod_sh);
          den_q <= COORD_WIDTH'(dv_q + DivisorWidth'(2));
          dv_q <= dv_q + DivisorWidth'(2);
          rem_q <= '0;
          cnt_q <= CntW'(NW);
          div_busy_q <= 1'b1;
          mul_busy_q <= 1'b0;
          mul_ph_q <= '0;
        end
      end
      unique case (cmd_i.op)
        DpLoad: begin
          ym_q <= ymag;
          xm_q <= xmag;
          yneg_q <= y_i[COORD_WIDTH-1];
          xneg_q <= x_i[COORD_WIDTH-1];
          inv_q <= ymag > xmag;
          special_q <= (xmag == '0);
        end
        DpDivStart: begin
          num_q <= NW'(sm) << RATIO_FRAC_BITS;
          den_q <= bg;
          rem_q <= '0;
          cnt_q <= CntW'(NW);
          div_busy_q <= 1'b1;
          sum_q <= '0;
          dv_q <= DivisorWidth'(1);
          mul_ph_q <= 2'd3;
        end
        DpTermAcc: begin
          if (mul_ph_q == 2'd3) begin
            q_q <= quot;
            p_q <= quot;
            mul_ph_q <= 2'd0;
          end
          if (cmd_i.odd) sum_q <= sum_q - (SumW+1)'(quot);
          else sum_q <= sum_q + (SumW+1)'(quot);
        end
        DpMulStart: begin
          mul_busy_q <= 1'b1;
          mul_ph_q <= 2'd1;
        end
        DpFinish: begin
          if (special_q) begin
            if (ym_q == '0) angle_q <= '0;
            else angle_q <= yneg_q ? -HalfPiQ : HalfPiQ;
          end else if (!xneg_q) angle_q <= r;
          else if (!yneg_q) angle_q <= r + PiQ;
          else angle_q <= r - PiQ;
        end
        default: ;
      endcase
    end
  end

  assign stat_o.busy = div_busy_q || mul_busy_q;
  assign stat_o.special = special_q;
  assign stat_o.below = quot < QW'(thresh_i);
  assign angle_o = angle_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_busy_q && mul_busy_q))
    else $error("divider and multiplier overlap");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy_q |-> den_q != '0)
    else $error("division by zero");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_busy_q && mul_ph_q == 2'd1) |=> mul_ph_q == 2'd2)
    else $error("multiply sequence broken");

endmodule

[hdl/two_argument_arctangent_series.sv]
// The result shows after the input transfer once the ratio division and every series term
// are done; each term waits on the bit-serial divider, so the wait grows with the term count.
// Inputs with x equal to zero (the y axis and the origin) skip the series and the divider.
// Throughput: one item at a time; a held result stalls the input until it transfers.
// Reset is asynchronous and active low; max_terms returns to 50, stop_threshold to 1.
module two_argument_arctangent_series #(
  parameter int unsigned COORD_WIDTH     = atan_pkg::CoordWidthDef,
  parameter int unsigned RATIO_FRAC_BITS = atan_pkg::RatioFracBitsDef
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [atan_pkg::CfgIdxWidth-1:0]        cfg_idx_i,
  input  logic [atan_pkg::CfgDataWidth-1:0]       cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]           y_coord_i,
  input  logic signed [COORD_WIDTH-1:0]           x_coord_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [atan_pkg::AngleWidth-1:0]  angle_o
);
  import atan_pkg::*;

  logic [MaxTermsWidth-1:0] max_terms_q;
  logic [ThreshWidth-1:0] thresh_q;
  dp_cmd_t cmd;
  dp_stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_terms_q <= MaxTermsWidth'(TermLimit);
      thresh_q <= ThreshWidth'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMaxTerms: max_terms_q <= cfg_data_i[MaxTermsWidth-1:0];
        CfgThresh:   thresh_q <= cfg_data_i[ThreshWidth-1:0];
        default: ;
      endcase
    end
  end

  atan_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .max_terms_i(max_terms_q), .stat_i(stat), .cmd_o(cmd)
  );

  atan_dp #(.COORD_WIDTH(COORD_WIDTH), .RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .y_i(y_coord_i), .x_i(x_coord_i), .thresh_i(thresh_q),
    .cmd_i(cmd), .stat_o(stat), .angle_o
  );

endmodule
